>>> rtl/pge_pkg.sv
package pge_pkg;

	localparam int PIX_W   = 24;
	localparam int CH_W    = 8;
	localparam int ID_W    = 20;
	localparam int WT_W    = 13;
	localparam int SUM_W   = 18;
	localparam int RAD_W   = 26;
	localparam int FRAC_W  = 4;
	localparam int CFG_W   = 11;
	localparam int IDX_W   = 2;
	localparam int BIT_W   = 4;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_EIGHT  = 2'd2;
	localparam logic [IDX_W-1:0] REG_COLOR  = 2'd3;

	localparam logic [1:0] NB_LEFT  = 2'd0;
	localparam logic [1:0] NB_UP    = 2'd1;
	localparam logic [1:0] NB_UPL   = 2'd2;
	localparam logic [1:0] NB_UPR   = 2'd3;

	typedef struct packed {
		logic       accept;
		logic       rd_up;
		logic       rd_ur;
		logic       diff;
		logic       sq;
		logic       root_step;
		logic       finish;
		logic [1:0] kind;
	} cmd_t;

	typedef struct packed {
		logic [3:0] mask;
		logic       color;
		logic       root_done;
		logic       last;
	} status_t;

	function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		absdiff = (a > b) ? a - b : b - a;
	endfunction

endpackage

>>> rtl/pge_ram.sv
module pge_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/pge_ctrl.sv
module pge_ctrl import pge_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t st,
	output cmd_t    cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD_UP = 4'd1;
	localparam logic [3:0] S_RD_UR = 4'd2;
	localparam logic [3:0] S_SEL   = 4'd3;
	localparam logic [3:0] S_DIFF  = 4'd4;
	localparam logic [3:0] S_SQ    = 4'd5;
	localparam logic [3:0] S_ROOT  = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		cmd       = '0;
		cmd.kind  = kind_q;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_RD_UP;
				end
			end
			S_RD_UP: begin
				cmd.rd_up = 1'b1;
				state_d   = S_RD_UR;
			end
			S_RD_UR: begin
				cmd.rd_ur = 1'b1;
				kind_d    = NB_LEFT;
				state_d   = S_SEL;
			end
			S_SEL: begin
				if (st.mask[kind_q]) begin
					state_d = S_DIFF;
				end else if (kind_q == NB_UPR) begin
					state_d = S_DONE;
				end else begin
					kind_d = kind_q + 2'd1;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SQ;
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = st.color ? S_ROOT : S_OUT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (st.root_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (st.last) begin
						state_d = S_DONE;
					end else begin
						kind_d  = kind_q + 2'd1;
						state_d = S_SEL;
					end
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= NB_LEFT;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end
endmodule

>>> rtl/pge_datapath.sv
module pge_datapath import pge_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic [PIX_W-1:0]        pix_in,
	input  cmd_t                    cmd,
	output status_t                 st,
	output logic [ID_W-1:0]         from_id,
	output logic [ID_W-1:0]         to_id,
	output logic [WT_W-1:0]         edge_weight
);
	localparam int CNTW = $clog2(MAX_WIDTH);
	localparam int RCNTW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
	localparam int CHW = (HW > CFG_W) ? HW : CFG_W;

	logic [CFG_W-1:0] width_q, height_q;
	logic             eight_q, color_q;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;

	logic [CNTW-1:0]  col_q;
	logic [RCNTW-1:0] row_q;
	logic [PIX_W-1:0] left_q, upl_q, cur_q, up_q, upr_q;
	logic [ID_W-1:0]  me_q;
	logic [3:0]       mask_q;
	logic [CH_W-1:0]  dr_q, dg_q, db_q;
	logic [SUM_W-1:0] sum_q;
	logic [WT_W-1:0]  wt_q;
	logic [BIT_W-1:0] bit_q;

	logic [PIX_W-1:0] ram_rdata, nb;
	logic [CNTW-1:0]  raddr;
	logic             col_end, row_end;
	logic [WT_W-1:0]  trial;
	logic [RAD_W-1:0] rad;
	logic [ID_W-1:0]  w20;

	always_comb begin
		if (CWW'(width_q) == '0) w_eff = WW'(1);
		else if (CWW'(width_q) > CWW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(width_q);
		if (CHW'(height_q) == '0) h_eff = HW'(1);
		else if (CHW'(height_q) > CHW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(height_q);
	end

	assign col_end = ((WW+1)'(col_q) + (WW+1)'(1)) >= (WW+1)'(w_eff);
	assign row_end = ((HW+1)'(row_q) + (HW+1)'(1)) >= (HW+1)'(h_eff);
	assign raddr   = cmd.rd_up ? col_q + CNTW'(1) : col_q;

	pge_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (cmd.rd_ur),
		.waddr (col_q),
		.wdata (cur_q),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (cmd.kind)
			NB_LEFT: nb = left_q;
			NB_UP:   nb = up_q;
			NB_UPL:  nb = upl_q;
			NB_UPR:  nb = upr_q;
			default: nb = left_q;
		endcase
	end

	assign trial = wt_q | (WT_W'(1) << bit_q);
	assign rad   = {sum_q, 8'd0};
	assign w20   = ID_W'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1024);
			height_q <= CFG_W'(1024);
			eight_q  <= 1'b0;
			color_q  <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			upl_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_EIGHT:  eight_q  <= cfg_data[0];
					REG_COLOR:  color_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.finish) begin
				left_q <= cur_q;
				upl_q  <= up_q;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + RCNTW'(1);
				end else begin
					col_q <= col_q + CNTW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q <= pix_in;
		end
		if (cmd.rd_up) begin
			up_q <= ram_rdata;
			me_q <= ID_W'(row_q) * ID_W'(w_eff) + ID_W'(col_q);
		end
		if (cmd.rd_ur) begin
			upr_q  <= ram_rdata;
			mask_q[0] <= col_q != '0;
			mask_q[1] <= row_q != '0;
			mask_q[2] <= (row_q != '0) && eight_q && (col_q != '0);
			mask_q[3] <= (row_q != '0) && eight_q && !col_end;
		end
		if (cmd.diff) begin
			dr_q <= absdiff(nb[23:16], cur_q[23:16]);
			dg_q <= absdiff(nb[15:8], cur_q[15:8]);
			db_q <= absdiff(nb[7:0], cur_q[7:0]);
		end
		if (cmd.sq) begin
			if (color_q) begin
				sum_q <= SUM_W'(dr_q) * SUM_W'(dr_q) + SUM_W'(dg_q) * SUM_W'(dg_q)
					+ SUM_W'(db_q) * SUM_W'(db_q);
				wt_q  <= '0;
				bit_q <= BIT_W'(WT_W - 1);
			end else begin
				wt_q <= {1'b0, dr_q, {FRAC_W{1'b0}}};
			end
		end
		if (cmd.root_step) begin
			if (RAD_W'(trial) * RAD_W'(trial) <= rad) begin
				wt_q <= trial;
			end
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	always_comb begin
		case (cmd.kind)
			NB_LEFT: from_id = me_q - ID_W'(1);
			NB_UP:   from_id = me_q - w20;
			NB_UPL:  from_id = me_q - w20 - ID_W'(1);
			NB_UPR:  from_id = me_q - w20 + ID_W'(1);
			default: from_id = me_q;
		endcase
	end

	assign to_id        = me_q;
	assign edge_weight  = wt_q;
	assign st.mask      = mask_q;
	assign st.color     = color_q;
	assign st.root_done = bit_q == '0;
	assign st.last      = (mask_q >> cmd.kind) <= 4'd1;
endmodule

>>> rtl/pixel_grid_edge_generator_top.sv
// Absent neighbor slots are skipped; in color mode each edge weight comes from a 13-step
// square root.
// One pixel at a time: a new pixel is accepted only after the last edge of the previous
// one has gone out, which output stalls can delay.
// arst_n clears counters, the left and upper-left neighbor registers and the controller; config returns to defaults.
module pixel_grid_edge_generator_top import pge_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,  // red_or_gray[7:0], green[15:8], blue[23:16]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,  // from_id[19:0], to_id[39:20], edge_weight[52:40]
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	cmd_t            cmd;
	status_t         st;
	logic [ID_W-1:0] from_id, to_id;
	logic [WT_W-1:0] edge_weight;

	pge_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	pge_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_in      ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
		.cmd         (cmd),
		.st          (st),
		.from_id     (from_id),
		.to_id       (to_id),
		.edge_weight (edge_weight)
	);

	assign m_tdata = {3'd0, edge_weight, to_id, from_id};
	assign m_tlast = st.last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output active together");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");

	a_more_edges: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !s_tready)
		else $error("pixel finished before last edge");
endmodule

>>> bench/tb.sv
module tb import pge_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ID_W-1:0] from_id;
		logic [ID_W-1:0] to_id;
		logic [WT_W-1:0] weight;
		logic            last;
	} edge_t;

	typedef struct {
		logic [23:0] rgb;   // {red_or_gray, green, blue}
		int          n_typed;  // -1: use predictor
		edge_t       typed_edge;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [23:0]      s_tdata;  // red_or_gray[7:0], green[15:8], blue[23:16]
	logic             m_tvalid;
	logic             m_tready;
	logic [55:0]      m_tdata;  // from_id[19:0], to_id[39:20], edge_weight[52:40]
	logic             m_tlast;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pixel_grid_edge_generator_top DUT (.*);

	// predictor state
	logic [CFG_W-1:0] width_reg, height_reg;
	logic             eight_on, color_on;
	int unsigned      col_cnt, row_cnt;
	logic [23:0]      line_buf [1024];
	logic [23:0]      left_px, upleft_px;

	edge_t edge_q[$];
	edge_t pred_q[$];
	int    failures, pixels_sent, edges_seen, random_pixels;
	bit    send_idle, recv_idle, hold_req;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
		if (v < 1) return 1;
		if (v > 1024) return 1024;
		return v;
	endfunction

	function automatic logic [7:0] chan_diff(logic [7:0] a, logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [WT_W-1:0] edge_cost(logic [23:0] p, logic [23:0] q);
		logic [7:0]  dr, dg, db;
		logic [31:0] s, lo, hi, mid;
		dr = chan_diff(p[23:16], q[23:16]);
		dg = chan_diff(p[15:8], q[15:8]);
		db = chan_diff(p[7:0], q[7:0]);
		if (!color_on) return {1'b0, dr, 4'b0};
		s = (32'(dr) * 32'(dr) + 32'(dg) * 32'(dg) + 32'(db) * 32'(db)) << 8;
		lo = 0;
		hi = 8191;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= s) lo = mid;
			else hi = mid - 1;
		end
		return lo[WT_W-1:0];
	endfunction

	task automatic predict_edges(input logic [23:0] cur);
		int unsigned w, h, me;
		logic [23:0] up, upr;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		up = line_buf[col_cnt];
		upr = (col_cnt + 1 < 1024) ? line_buf[col_cnt + 1] : '0;
		me = row_cnt * w + col_cnt;
		pred_q.delete();
		if (col_cnt > 0)
			pred_q.insert(pred_q.size(),
				edge_t'{20'(me - 1), 20'(me), edge_cost(left_px, cur), 1'b0});
		if (row_cnt > 0) begin
			pred_q.insert(pred_q.size(),
				edge_t'{20'(me - w), 20'(me), edge_cost(up, cur), 1'b0});
			if (eight_on) begin
				if (col_cnt > 0)
					pred_q.insert(pred_q.size(),
						edge_t'{20'(me - w - 1), 20'(me), edge_cost(upleft_px, cur), 1'b0});
				if (col_cnt + 1 < w)
					pred_q.insert(pred_q.size(),
						edge_t'{20'(me - w + 1), 20'(me), edge_cost(upr, cur), 1'b0});
			end
		end
		if (pred_q.size() > 0) pred_q[$].last = 1'b1;
		upleft_px = up;
		left_px = cur;
		line_buf[col_cnt] = cur;
		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
		end else begin
			col_cnt = col_cnt + 1;
		end
	endtask

	task automatic send_pixel(input row_t r);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r.rgb[7:0], r.rgb[15:8], r.rgb[23:16]};
		do @(posedge clk); while (!s_tready);
		predict_edges(r.rgb);
		pixels_sent++;
		if (r.n_typed < 0) begin
			foreach (pred_q[i]) edge_q.insert(edge_q.size(), pred_q[i]);
		end else if (r.n_typed > 0) begin
			edge_q.insert(edge_q.size(), r.typed_edge);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (edge_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH:  width_reg = val;
			REG_HEIGHT: height_reg = val;
			REG_EIGHT:  eight_on = val[0];
			REG_COLOR:  color_on = val[0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic eight, input logic color);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_EIGHT, {10'b0, eight});
		write_reg(REG_COLOR, {10'b0, color});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [23:0] rand_pixel(int style);
		case (style)
			0: return {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
				$urandom_range(0, 1) ? 8'hff : 8'h00};
			1: return {8'($urandom_range(120, 136)), 8'($urandom_range(120, 136)),
				8'($urandom_range(120, 136))};
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_run(input int style, input int n, input bit counted);
		row_t r;
		r.n_typed = -1;
		r.typed_edge = '0;
		repeat (n) begin
			r.rgb = rand_pixel(style);
			send_pixel(r);
			if (counted) random_pixels++;
		end
	endtask

	task automatic send_frame(input int style, input bit counted);
		send_run(style, clamp_dim(width_reg) * clamp_dim(height_reg), counted);
	endtask

	// receiver and checker
	initial begin
		int burst, hold_left;
		edge_t got, want;
		m_tready = 1'b0;
		burst = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[19:0], m_tdata[39:20], m_tdata[52:40], m_tlast};
				edges_seen++;
				if (edge_q.size() == 0) begin
					$error("edge transaction with nothing expected: from %0d to %0d",
						got.from_id, got.to_id);
					failures++;
				end else begin
					want = edge_q.pop_front();
					if (got.from_id !== want.from_id) begin
						$error("from_id expected %0d actual %0d", want.from_id, got.from_id);
						failures++;
					end
					if (got.to_id !== want.to_id) begin
						$error("to_id expected %0d actual %0d", want.to_id, got.to_id);
						failures++;
					end
					if (got.weight !== want.weight) begin
						$error("edge_weight expected %0d actual %0d", want.weight, got.weight);
						failures++;
					end
					if (got.last !== want.last) begin
						$error("last_edge expected %0d actual %0d", want.last, got.last);
						failures++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				m_tready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("timeout with %0d edges outstanding", edge_q.size());
		$display("pixel_grid_edge_generator_top regression: fail");
		$finish;
	end

	initial begin
		row_t dir_rows[$];
		int frames, w_pick, h_pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		failures = 0;
		pixels_sent = 0;
		edges_seen = 0;
		random_pixels = 0;
		send_idle = 1;
		recv_idle = 1;
		hold_req = 0;
		width_reg = 1024;
		height_reg = 1024;
		eight_on = 0;
		color_on = 0;
		col_cnt = 0;
		row_cnt = 0;
		left_px = '0;
		upleft_px = '0;
		foreach (line_buf[i]) line_buf[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2 gray, eight neighbors
		set_geometry(2, 2, 1, 0);
		dir_rows = '{
			'{24'h000000, 0, '0},
			'{24'hff0000, 1, '{20'd0, 20'd1, 13'd4080, 1'b1}},
			'{24'hff0000, -1, '0},
			'{24'h00ffff, -1, '0}
		};
		foreach (dir_rows[i]) send_pixel(dir_rows[i]);
		drain();
		// 2x1 color, full-scale distance
		set_geometry(2, 1, 0, 1);
		dir_rows = '{
			'{24'h000000, 0, '0},
			'{24'hffffff, 1, '{20'd0, 20'd1, 13'd7066, 1'b1}}
		};
		foreach (dir_rows[i]) send_pixel(dir_rows[i]);
		drain();
		// 3x3 color, eight neighbors, saturated channels
		set_geometry(3, 3, 1, 1);
		dir_rows = '{
			'{24'hffffff, -1, '0}, '{24'h000000, -1, '0}, '{24'hff00ff, -1, '0},
			'{24'h00ff00, -1, '0}, '{24'hffffff, -1, '0}, '{24'h000000, -1, '0},
			'{24'h0000ff, -1, '0}, '{24'hff0000, -1, '0}, '{24'h7f807f, -1, '0}
		};
		foreach (dir_rows[i]) send_pixel(dir_rows[i]);
		drain();
		// single pixel frames: no edges ever
		set_geometry(0, 0, 1, 1);
		send_frame(2, 0);
		send_frame(0, 0);
		drain();

		// clamped extremes: start of a full-width row, then shrink the width mid-row
		set_geometry(11'h7ff, 1, 1, 0);
		send_run(2, 24, 0);
		drain();
		write_reg(REG_WIDTH, 11'd1);
		cfg_we <= 1'b0;
		send_run(2, 1, 0);
		drain();
		// start of a full-height column, then shrink the height mid-frame
		set_geometry(0, 11'h7ff, 1, 1);
		send_run(0, 24, 0);
		drain();
		write_reg(REG_HEIGHT, 11'd1);
		cfg_we <= 1'b0;
		send_run(0, 1, 0);
		drain();

		// random frames
		frames = 0;
		while (pixels_sent < 400) begin
			if (pixels_sent > 340) begin
				send_idle = 0;
				recv_idle = 0;
			end
			w_pick = $urandom_range(1, 9);
			h_pick = $urandom_range(1, 6);
			if (frames == 3) begin
				w_pick = 6;
				h_pick = 4;
			end
			set_geometry(11'(w_pick), 11'(h_pick),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if (frames == 3) hold_req = 1;
			send_frame($urandom_range(0, 4), 1);
			drain();
			frames++;
		end

		$display("%0d pixels (%0d in %0d random frames) plus directed and clamped-size runs,",
			pixels_sent, random_pixels, frames);
		$display("%0d edges checked in gray and color, four- and eight-connected", edges_seen);
		if (failures == 0 && edge_q.size() == 0)
			$display("pixel_grid_edge_generator_top regression: pass");
		else
			$display("pixel_grid_edge_generator_top regression: fail");
		$finish;
	end

endmodule
